// ----- hw/rtl/request_ring_with_prepone_unit_assert.svh -----
// Assertion macros for the request ring with prepone unit.
`ifndef REQUEST_RING_WITH_PREPONE_UNIT_ASSERT_SVH
`define REQUEST_RING_WITH_PREPONE_UNIT_ASSERT_SVH

`ifndef SYNTH
`define RRP_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rrp assertion failed");
`define RRP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rrp assertion failed");
`else
`define RRP_ASSERT_SAME(lbl, ante, cons)
`define RRP_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ----- hw/rtl/rrp_pkg.sv -----
// Shared types, constants and helpers of the request ring with prepone unit.
`timescale 1ns / 1ps
`default_nettype none
package rrp_pkg;

  localparam int QUEUE_SLOTS   = 16;
  localparam int PTR_W         = $clog2(QUEUE_SLOTS);
  localparam int USED_W        = $clog2(QUEUE_SLOTS + 1);
  localparam int CMP_W         = USED_W + 5;
  localparam logic [3:0] PREPONE_CAP_RESET = 4'd8;

  localparam logic [1:0] MODE_ENQ     = 2'd0;
  localparam logic [1:0] MODE_DEQ     = 2'd1;
  localparam logic [1:0] MODE_PREPONE = 2'd2;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;

  typedef struct packed {
    logic [3:0] chan;
    logic       short_flag;
  } slot_t;

  typedef struct packed {
    logic             we;
    logic [PTR_W-1:0] waddr;
    slot_t            wdata;
    logic [PTR_W-1:0] raddr;
  } ram_req_t;

  typedef struct packed {
    logic       strobe;
    logic [1:0] status;
    logic [3:0] head_chan;
    logic       head_valid;
    logic [4:0] occupancy;
    logic [3:0] moves_done;
    logic       none_moved;
    logic       made_progress;
  } result_t;

  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
    ring_next = (p == PTR_W'(QUEUE_SLOTS - 1)) ? '0 : p + PTR_W'(1);
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/rrp_slot_ram.sv -----
// Slot store of the ring: one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module rrp_slot_ram (
  input  wire logic              clk,
  input  wire rrp_pkg::ram_req_t req,
  output rrp_pkg::slot_t         rdata
);
  import rrp_pkg::*;

  slot_t mem [QUEUE_SLOTS];
  slot_t rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata_r <= mem[req.raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// ----- hw/rtl/rrp_seq.sv -----
// Sequencer that runs enqueue, dequeue and the slot-by-slot prepone walk.
`timescale 1ns / 1ps
`default_nettype none
module rrp_seq (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [1:0]        mode,
  input  wire logic [3:0]        chan_id,
  input  wire logic              is_short,
  input  wire logic [3:0]        max_prepone,
  input  wire rrp_pkg::slot_t    rdata,
  output rrp_pkg::ram_req_t      req,
  output logic                   busy,
  output rrp_pkg::result_t       res
);
  import rrp_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_LOAD, S_STEP, S_END, S_FETCH, S_LATCH
  } state_t;

  state_t            state_r, state_nxt;
  logic [PTR_W-1:0]  head_r, head_nxt;
  logic [PTR_W-1:0]  tail_r, tail_nxt;
  logic [USED_W-1:0] used_r, used_nxt;
  logic [PTR_W-1:0]  pos_r, pos_nxt;
  logic [3:0]        moves_r, moves_nxt;
  slot_t             carry_r, carry_nxt;
  logic [1:0]        status_r, status_nxt;
  logic              none_r, none_nxt;
  logic              prog_r, prog_nxt;
  result_t           res_r, res_nxt;
  logic [PTR_W-1:0]  pos_adv;
  logic [3:0]        moves_inc;

  function automatic logic loop_go(input logic [3:0] m, input logic [3:0] lim,
                                   input logic [USED_W-1:0] u);
    loop_go = (m < lim) && ((CMP_W'(m) + CMP_W'(1)) < CMP_W'(u));
  endfunction

  always_comb begin
    state_nxt  = state_r;
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    used_nxt   = used_r;
    pos_nxt    = pos_r;
    moves_nxt  = moves_r;
    carry_nxt  = carry_r;
    status_nxt = status_r;
    none_nxt   = none_r;
    prog_nxt   = prog_r;
    res_nxt    = res_r;
    res_nxt.strobe = 1'b0;
    req        = '0;
    pos_adv    = ring_next(pos_r);
    moves_inc  = moves_r + 4'd1;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          status_nxt = STAT_OK;
          moves_nxt  = '0;
          none_nxt   = 1'b0;
          prog_nxt   = 1'b0;
          state_nxt  = S_FETCH;
          case (mode)
            MODE_ENQ: begin
              if (used_r == USED_W'(QUEUE_SLOTS)) begin
                status_nxt = STAT_FULL;
              end else begin
                req.we               = 1'b1;
                req.waddr            = tail_r;
                req.wdata.chan       = chan_id;
                req.wdata.short_flag = is_short;
                tail_nxt             = ring_next(tail_r);
                used_nxt             = used_r + USED_W'(1);
                prog_nxt             = 1'b1;
              end
            end
            MODE_DEQ: begin
              if (used_r == '0) begin
                status_nxt = STAT_EMPTY;
              end else begin
                head_nxt = ring_next(head_r);
                used_nxt = used_r - USED_W'(1);
                prog_nxt = 1'b1;
              end
            end
            MODE_PREPONE: begin
              if (used_r == '0) begin
                status_nxt = STAT_EMPTY;
              end else begin
                req.raddr = head_r;
                pos_nxt   = head_r;
                state_nxt = S_LOAD;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_LOAD: begin
        carry_nxt = rdata;
        if (loop_go(4'd0, max_prepone, used_r)) begin
          req.raddr = pos_adv;
          state_nxt = S_STEP;
        end else begin
          state_nxt = S_END;
        end
      end
      S_STEP: begin
        if (!rdata.short_flag) begin
          state_nxt = S_END;
        end else begin
          req.we    = 1'b1;
          req.waddr = pos_r;
          req.wdata = rdata;
          pos_nxt   = pos_adv;
          moves_nxt = moves_inc;
          if (loop_go(moves_inc, max_prepone, used_r)) begin
            req.raddr = ring_next(pos_adv);
          end else begin
            state_nxt = S_END;
          end
        end
      end
      S_END: begin
        req.we    = 1'b1;
        req.waddr = pos_r;
        req.wdata = carry_r;
        none_nxt  = (moves_r == '0);
        prog_nxt  = 1'b1;
        state_nxt = S_FETCH;
      end
      S_FETCH: begin
        req.raddr = head_r;
        state_nxt = S_LATCH;
      end
      S_LATCH: begin
        res_nxt.strobe        = 1'b1;
        res_nxt.status        = status_r;
        res_nxt.head_chan     = (used_r != '0) ? rdata.chan : 4'd0;
        res_nxt.head_valid    = (used_r != '0);
        res_nxt.occupancy     = 5'(used_r);
        res_nxt.moves_done    = moves_r;
        res_nxt.none_moved    = none_r;
        res_nxt.made_progress = prog_r;
        state_nxt             = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      head_r     <= '0;
      tail_r     <= '0;
      used_r     <= '0;
      res_r      <= '0;
    end else begin
      state_r    <= state_nxt;
      head_r     <= head_nxt;
      tail_r     <= tail_nxt;
      used_r     <= used_nxt;
      res_r      <= res_nxt;
    end
    pos_r    <= pos_nxt;
    moves_r  <= moves_nxt;
    carry_r  <= carry_nxt;
    status_r <= status_nxt;
    none_r   <= none_nxt;
    prog_r   <= prog_nxt;
  end

  assign busy = (state_r != S_IDLE);
  assign res  = res_r;

endmodule
`default_nettype wire

// ----- hw/rtl/request_ring_with_prepone_unit.sv -----
// Top level of the request ring with prepone unit.
//
//   Channel  Ports                               Handshake
//   input    in_mode, in_chan_id, in_is_short    start high while busy is low
//   result   out_status ... out_made_progress    out_strobe high for one cycle
//   config   cfg_we, cfg_wdata                   cfg_we high, no wait
//
// Enqueue, dequeue and the unused mode go through the fetch and latch states to the
// registered result strobe. A prepone loads the head entry and moves it past the short
// entries behind it, up to max_prepone moves and stopping on a long entry, then writes it back and fetches.
// Each prepone move writes one slot and, unless it is the last move, reads the next slot in the same cycle.
// Reset is synchronous and clears the pointers and the count; max_prepone resets to 8.
// Busy stays high from the accepting edge until the result strobe cycle.
// The receiver cannot stall results.
`timescale 1ns / 1ps
`default_nettype none
module request_ring_with_prepone_unit (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  output logic            busy,
  input  wire logic [1:0] in_mode,
  input  wire logic [3:0] in_chan_id,
  input  wire logic       in_is_short,
  input  wire logic       cfg_we,
  input  wire logic [3:0] cfg_wdata,
  output logic            out_strobe,
  output logic [1:0]      out_status,
  output logic [3:0]      out_head_chan,
  output logic            out_head_valid,
  output logic [4:0]      out_occupancy,
  output logic [3:0]      out_moves_done,
  output logic            out_none_moved,
  output logic            out_made_progress
);
  import rrp_pkg::*;

`include "request_ring_with_prepone_unit_assert.svh"

  logic [3:0] max_prepone_r;
  ram_req_t   ram_req;
  slot_t      ram_rdata;
  result_t    res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_prepone_r <= PREPONE_CAP_RESET;
    end else if (cfg_we) begin
      max_prepone_r <= cfg_wdata;
    end
  end

  rrp_slot_ram u_ram (
    .clk   (clk),
    .req   (ram_req),
    .rdata (ram_rdata)
  );

  rrp_seq u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .mode        (in_mode),
    .chan_id     (in_chan_id),
    .is_short    (in_is_short),
    .max_prepone (max_prepone_r),
    .rdata       (ram_rdata),
    .req         (ram_req),
    .busy        (busy),
    .res         (res)
  );

  assign out_strobe        = res.strobe;
  assign out_status        = res.status;
  assign out_head_chan     = res.head_chan;
  assign out_head_valid    = res.head_valid;
  assign out_occupancy     = res.occupancy;
  assign out_moves_done    = res.moves_done;
  assign out_none_moved    = res.none_moved;
  assign out_made_progress = res.made_progress;

  `RRP_ASSERT_SAME(a_strobe_idle, out_strobe, !busy)
  `RRP_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  `RRP_ASSERT_SAME(a_valid_occ, out_strobe, out_head_valid == (out_occupancy != 5'd0))
  `RRP_ASSERT_SAME(a_moves_flag, out_strobe && (out_moves_done != 4'd0), !out_none_moved)

endmodule
`default_nettype wire

// ----- test/tb_request_ring_with_prepone_unit.sv -----
// Self-checking testbench for the request ring with prepone unit.
`timescale 1ns / 1ps
module tb_request_ring_with_prepone_unit;
  import rrp_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int WORD_TARGET = 1300;

  typedef enum logic [1:0] {OP_WORD, OP_CFG, OP_DRAIN} op_kind_t;

  typedef struct {
    op_kind_t   kind;
    logic [1:0] mode;
    logic [3:0] chan;
    logic       is_short;
    logic [3:0] cap;
  } ring_op_t;

  typedef struct {
    logic [1:0] status;
    logic [3:0] head_chan;
    logic       head_valid;
    logic [4:0] occupancy;
    logic [3:0] moves_done;
    logic       none_moved;
    logic       made_progress;
  } ring_result_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  logic [1:0] in_mode = MODE_ENQ;
  logic [3:0] in_chan_id = 4'd0;
  logic       in_is_short = 1'b0;
  logic       cfg_we = 1'b0;
  logic [3:0] cfg_wdata = 4'd0;
  logic       out_strobe;
  logic [1:0] out_status;
  logic [3:0] out_head_chan;
  logic       out_head_valid;
  logic [4:0] out_occupancy;
  logic [3:0] out_moves_done;
  logic       out_none_moved;
  logic       out_made_progress;

  ring_op_t     ring_ops_q[$];
  ring_result_t due_results[$];

  logic [3:0] chan_mem [QUEUE_SLOTS];
  logic       short_mem[QUEUE_SLOTS];
  logic [3:0] head_idx;
  logic [3:0] tail_idx;
  int         fill_level;
  logic [3:0] prepone_cap;

  logic word_taken = 1'b0;
  int   burst_left = 1;
  int   gap_left = 0;
  int   words_queued = 0;
  int   error_count = 0;
  int   results_seen = 0;
  int   full_rejects = 0;
  int   empty_rejects = 0;
  int   prepones_moved = 0;
  int   longest_walk = 0;

  request_ring_with_prepone_unit dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_mode(in_mode), .in_chan_id(in_chan_id), .in_is_short(in_is_short),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .out_strobe(out_strobe), .out_status(out_status), .out_head_chan(out_head_chan),
    .out_head_valid(out_head_valid), .out_occupancy(out_occupancy),
    .out_moves_done(out_moves_done), .out_none_moved(out_none_moved),
    .out_made_progress(out_made_progress)
  );

  always #10 clk = ~clk;

  task automatic report_mismatch(string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic check_field(string name, int got, int want);
    if (got != want)
      report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
  endtask

  function automatic ring_result_t ring_step(logic [1:0] mode, logic [3:0] chan, logic sh);
    ring_result_t r;
    logic [3:0] pos;
    logic [3:0] nxt;
    logic [3:0] tc;
    logic       ts;
    int         offset;
    int         moves;
    r = '{default: '0};
    moves = 0;
    if (mode == MODE_ENQ) begin
      if (fill_level >= QUEUE_SLOTS) begin
        r.status = STAT_FULL;
      end else begin
        chan_mem[tail_idx] = chan;
        short_mem[tail_idx] = sh;
        tail_idx = tail_idx + 4'd1;
        fill_level++;
        r.made_progress = 1'b1;
      end
    end else if (mode == MODE_DEQ) begin
      if (fill_level == 0) begin
        r.status = STAT_EMPTY;
      end else begin
        head_idx = head_idx + 4'd1;
        fill_level--;
        r.made_progress = 1'b1;
      end
    end else if (mode == MODE_PREPONE) begin
      if (fill_level == 0) begin
        r.status = STAT_EMPTY;
      end else begin
        pos = head_idx;
        offset = 0;
        while (moves < prepone_cap && offset + 1 < fill_level) begin
          nxt = pos + 4'd1;
          if (!short_mem[nxt]) break;
          tc = chan_mem[nxt];
          ts = short_mem[nxt];
          chan_mem[nxt] = chan_mem[pos];
          short_mem[nxt] = short_mem[pos];
          chan_mem[pos] = tc;
          short_mem[pos] = ts;
          pos = nxt;
          offset++;
          moves++;
        end
        r.moves_done = 4'(moves);
        r.none_moved = (moves == 0);
        r.made_progress = 1'b1;
      end
    end
    r.head_chan = (fill_level != 0) ? chan_mem[head_idx] : 4'd0;
    r.head_valid = (fill_level != 0);
    r.occupancy = 5'(fill_level);
    return r;
  endfunction

  always @(posedge clk) begin
    ring_result_t want;
    word_taken <= rst_n && start && !busy;
    if (!rst_n) begin
      head_idx = '0;
      tail_idx = '0;
      fill_level = 0;
      prepone_cap = PREPONE_CAP_RESET;
    end else begin
      if (out_strobe) begin
        if (due_results.size() == 0) begin
          report_mismatch("result strobe with no result due");
        end else begin
          want = due_results.pop_front();
          results_seen++;
          check_field("status", out_status, want.status);
          check_field("head_chan", out_head_chan, want.head_chan);
          check_field("head_valid", out_head_valid, want.head_valid);
          check_field("occupancy", out_occupancy, want.occupancy);
          check_field("moves_done", out_moves_done, want.moves_done);
          check_field("none_moved", out_none_moved, want.none_moved);
          check_field("made_progress", out_made_progress, want.made_progress);
        end
      end
      if (cfg_we) prepone_cap = cfg_wdata;
      if (start && !busy) begin
        want = ring_step(in_mode, in_chan_id, in_is_short);
        if (want.status == STAT_FULL) full_rejects++;
        if (want.status == STAT_EMPTY) empty_rejects++;
        if (want.moves_done != 0) prepones_moved++;
        if (want.moves_done > longest_walk) longest_walk = want.moves_done;
        due_results.push_back(want);
      end
    end
  end

  always @(negedge clk) begin
    logic     nxt_start;
    logic     nxt_we;
    logic     quiet;
    ring_op_t op;
    nxt_start = start;
    nxt_we = 1'b0;
    quiet = !busy && due_results.size() == 0;
    if (rst_n && !(start && !word_taken)) begin
      nxt_start = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (ring_ops_q.size() > 0) begin
        op = ring_ops_q[0];
        case (op.kind)
          OP_WORD: begin
            in_mode <= op.mode;
            in_chan_id <= op.chan;
            in_is_short <= op.is_short;
            nxt_start = 1'b1;
            void'(ring_ops_q.pop_front());
            if (burst_left > 1) begin
              burst_left--;
            end else begin
              burst_left = $urandom_range(1, 24);
              case ($urandom_range(0, 3))
                0: gap_left = 0;
                1: gap_left = $urandom_range(1, 4);
                2: gap_left = $urandom_range(5, 12);
                default: gap_left = $urandom_range(13, 30);
              endcase
            end
          end
          OP_CFG: begin
            if (quiet) begin
              nxt_we = 1'b1;
              cfg_wdata <= op.cap;
              void'(ring_ops_q.pop_front());
            end
          end
          default: begin
            if (quiet) void'(ring_ops_q.pop_front());
          end
        endcase
      end
    end
    start <= nxt_start;
    cfg_we <= nxt_we;
  end

  task automatic add_word(logic [1:0] mode, logic [3:0] chan, logic sh);
    ring_op_t op;
    op = '{kind: OP_WORD, mode: mode, chan: chan, is_short: sh, cap: 4'd0};
    ring_ops_q.push_back(op);
    if (mode != MODE_UNUSED) words_queued++;
  endtask

  task automatic add_cap(logic [3:0] cap);
    ring_op_t op;
    op = '{kind: OP_CFG, mode: MODE_ENQ, chan: 4'd0, is_short: 1'b0, cap: cap};
    ring_ops_q.push_back(op);
  endtask

  task automatic add_drain();
    ring_op_t op;
    op = '{kind: OP_DRAIN, mode: MODE_ENQ, chan: 4'd0, is_short: 1'b0, cap: 4'd0};
    ring_ops_q.push_back(op);
  endtask

  task automatic add_long_walk();
    repeat (QUEUE_SLOTS + 1) add_word(MODE_DEQ, 4'($urandom), 1'($urandom));
    add_word(MODE_ENQ, 4'($urandom), 1'b0);
    repeat (QUEUE_SLOTS - 1) add_word(MODE_ENQ, 4'($urandom), 1'b1);
    add_word(MODE_PREPONE, 4'($urandom), 1'($urandom));
  endtask

  task automatic add_random_phase(int count, logic [3:0] cap);
    int enq_pct;
    int r;
    logic [1:0] mode;
    add_cap(cap);
    case ($urandom_range(0, 2))
      0: enq_pct = 35;
      1: enq_pct = 50;
      default: enq_pct = 70;
    endcase
    if (cap == 4'd15 || $urandom_range(0, 1) == 1) add_long_walk();
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 4) mode = MODE_UNUSED;
      else if (r < enq_pct) mode = MODE_ENQ;
      else if (r < enq_pct + (100 - enq_pct) / 2) mode = MODE_PREPONE;
      else mode = MODE_DEQ;
      add_word(mode, 4'($urandom), ($urandom_range(0, 3) != 0));
      if (i == count / 2 && $urandom_range(0, 2) == 0) add_drain();
    end
  endtask

  initial begin
    int phase;
    logic [3:0] cap;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    add_word(MODE_DEQ, 4'd0, 1'b0);
    add_word(MODE_PREPONE, 4'd0, 1'b0);
    add_word(MODE_UNUSED, 4'd15, 1'b1);
    add_word(MODE_ENQ, 4'd15, 1'b0);
    add_word(MODE_PREPONE, 4'd0, 1'b0);
    add_word(MODE_ENQ, 4'd0, 1'b1);
    add_word(MODE_ENQ, 4'd5, 1'b1);
    add_word(MODE_ENQ, 4'd10, 1'b1);
    add_word(MODE_ENQ, 4'd3, 1'b0);
    add_word(MODE_ENQ, 4'd7, 1'b1);
    add_word(MODE_PREPONE, 4'd15, 1'b1);
    add_word(MODE_PREPONE, 4'd0, 1'b0);
    add_word(MODE_DEQ, 4'd9, 1'b1);
    add_word(MODE_ENQ, 4'd9, 1'b1);
    add_cap(4'd0);
    add_word(MODE_PREPONE, 4'd0, 1'b0);
    add_cap(4'd15);
    add_word(MODE_PREPONE, 4'd0, 1'b0);
    add_word(MODE_DEQ, 4'd0, 1'b0);
    add_word(MODE_PREPONE, 4'd0, 1'b0);
    add_drain();

    phase = 0;
    while (words_queued < WORD_TARGET) begin
      case (phase)
        0: cap = 4'd15;
        1: cap = 4'd0;
        2: cap = 4'd1;
        3: cap = 4'd8;
        default: cap = 4'($urandom_range(0, 15));
      endcase
      add_random_phase(100, cap);
      phase++;
    end

    while (ring_ops_q.size() != 0 || start || due_results.size() != 0) @(negedge clk);
    repeat (40) @(posedge clk);
    $display("Covered %0d results over %0d setting phases: %0d full, %0d empty rejects.",
             results_seen, phase, full_rejects, empty_rejects);
    $display("Prepones that moved an entry: %0d, longest walk %0d slots.",
             prepones_moved, longest_walk);
    if (error_count == 0) begin
      $display("PASS request_ring_with_prepone_unit");
    end else begin
      $display("FAIL request_ring_with_prepone_unit");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("FAIL request_ring_with_prepone_unit");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/rrp_pkg.sv
hw/rtl/rrp_slot_ram.sv
hw/rtl/rrp_seq.sv
hw/rtl/request_ring_with_prepone_unit.sv
test/tb_request_ring_with_prepone_unit.sv
